@@ src/i2cs_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cs_pkg
// Shared constants and types for the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cs_pkg;

    // Byte buffer geometry
    localparam int BUF_DEPTH = 256;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);

    // Request function codes
    localparam logic [2:0] FN_LOAD    = 3'd0;
    localparam logic [2:0] FN_START_W = 3'd1;
    localparam logic [2:0] FN_START_R = 3'd2;
    localparam logic [2:0] FN_EVENT   = 3'd3;
    localparam logic [2:0] FN_ERROR   = 3'd4;
    localparam logic [2:0] FN_READBUF = 3'd5;

    // Transfer states
    localparam logic [2:0] ST_READY   = 3'd0;
    localparam logic [2:0] ST_BUSY_TX = 3'd1;
    localparam logic [2:0] ST_BUSY_RX = 3'd2;
    localparam logic [2:0] ST_NACK    = 3'd3;
    localparam logic [2:0] ST_BUSERR  = 3'd4;
    localparam logic [2:0] ST_ARLO    = 3'd5;
    localparam logic [2:0] ST_OVR     = 3'd6;

    // Ack and interrupt control codes
    localparam logic [1:0] CTL_KEEP = 2'd0;
    localparam logic [1:0] CTL_SET  = 2'd1;
    localparam logic [1:0] CTL_CLR  = 2'd2;

    // Error flag bit positions
    localparam int ERR_AF   = 0;
    localparam int ERR_BERR = 1;
    localparam int ERR_ARLO = 2;
    localparam int ERR_OVR  = 3;

    localparam logic [7:0] READ_BIT_MASK = 8'h01;

    // Actions decided for one request, buffer data filled in at the output register
    typedef struct packed {
        logic       cmd_status;
        logic [2:0] state;
        logic       dr_valid;
        logic       dr_from_mem;
        logic [7:0] dr_data;
        logic       gen_start;
        logic       gen_stop;
        logic [1:0] ack_ctrl;
        logic [1:0] irq_ctrl;
        logic       clear_addr;
        logic       rd_from_mem;
    } t_act;

    // Buffer memory access for one request
    typedef struct packed {
        logic              re;
        logic [BUF_AW-1:0] raddr;
        logic              we;
        logic [BUF_AW-1:0] waddr;
        logic [7:0]        wdata;
    } t_mreq;

endpackage

@@ src/i2cs_buf_ram.sv @@
// ----------------------------------------------------------------------------
// i2cs_buf_ram
// Simple dual-port byte buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module i2cs_buf_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/i2cs_seq.sv @@
// ----------------------------------------------------------------------------
// i2cs_seq
// Transfer state, counters and per-request action decode.
// ----------------------------------------------------------------------------
module i2cs_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [2:0]        i_func,
    input  logic [7:0]        i_target_addr,
    input  logic [8:0]        i_length,
    input  logic [7:0]        i_index,
    input  logic [7:0]        i_data_byte,
    input  logic              i_flag_sb,
    input  logic              i_flag_addr,
    input  logic              i_flag_txe,
    input  logic              i_flag_btf,
    input  logic              i_flag_rxne,
    input  logic [3:0]        i_error_flags,
    output i2cs_pkg::t_act    o_act,
    output i2cs_pkg::t_mreq   o_mreq
);

    logic [2:0]                  r_state, n_state;
    logic [7:0]                  r_addr_byte, n_addr_byte;
    logic [8:0]                  r_left, n_left;
    logic [i2cs_pkg::BUF_AW-1:0] r_pos, n_pos;
    i2cs_pkg::t_act              act;
    i2cs_pkg::t_mreq             mreq;

    // Decode one request against the current state
    always_comb begin
        n_state     = r_state;
        n_addr_byte = r_addr_byte;
        n_left      = r_left;
        n_pos       = r_pos;
        act         = '0;
        mreq        = '0;
        unique case (i_func)
            i2cs_pkg::FN_LOAD: begin
                mreq.we    = 1'b1;
                mreq.waddr = i_index[i2cs_pkg::BUF_AW-1:0];
                mreq.wdata = i_data_byte;
            end
            i2cs_pkg::FN_START_W, i2cs_pkg::FN_START_R: begin
                if (r_state != i2cs_pkg::ST_READY) begin
                    act.cmd_status = 1'b1;
                end else begin
                    n_left        = i_length;
                    n_pos         = '0;
                    act.gen_start = 1'b1;
                    act.irq_ctrl  = i2cs_pkg::CTL_SET;
                    if (i_func == i2cs_pkg::FN_START_W) begin
                        n_addr_byte = i_target_addr;
                        n_state     = i2cs_pkg::ST_BUSY_TX;
                    end else begin
                        n_addr_byte  = i_target_addr | i2cs_pkg::READ_BIT_MASK;
                        n_state      = i2cs_pkg::ST_BUSY_RX;
                        act.ack_ctrl = i2cs_pkg::CTL_SET;
                    end
                end
            end
            i2cs_pkg::FN_EVENT: begin
                if (i_flag_sb) begin
                    // start sent: address byte goes out, nothing else
                    act.dr_valid = 1'b1;
                    act.dr_data  = r_addr_byte;
                end else begin
                    if (i_flag_addr) begin
                        if (r_state == i2cs_pkg::ST_BUSY_RX && r_left == 9'd1) begin
                            act.ack_ctrl = i2cs_pkg::CTL_CLR;
                            act.gen_stop = 1'b1;
                        end
                        act.clear_addr = 1'b1;
                    end
                    // next transmit byte from the buffer
                    if (i_flag_txe && !i_flag_btf && r_state == i2cs_pkg::ST_BUSY_TX
                        && r_left != 9'd0) begin
                        act.dr_valid    = 1'b1;
                        act.dr_from_mem = 1'b1;
                        mreq.re         = 1'b1;
                        mreq.raddr      = r_pos;
                        n_pos           = r_pos + 1'b1;
                        n_left          = r_left - 9'd1;
                    end
                    // received byte into the buffer
                    if (i_flag_rxne) begin
                        mreq.we    = 1'b1;
                        mreq.waddr = n_pos;
                        mreq.wdata = i_data_byte;
                        n_pos      = n_pos + 1'b1;
                        if (n_left > 9'd1) begin
                            if (n_left == 9'd2) begin
                                act.ack_ctrl = i2cs_pkg::CTL_CLR;
                                act.gen_stop = 1'b1;
                            end
                            n_left = n_left - 9'd1;
                        end else begin
                            n_state      = i2cs_pkg::ST_READY;
                            act.irq_ctrl = i2cs_pkg::CTL_CLR;
                        end
                    end
                    // last byte out on the wire
                    if (i_flag_btf && n_state == i2cs_pkg::ST_BUSY_TX && n_left == 9'd0) begin
                        act.gen_stop = 1'b1;
                        act.irq_ctrl = i2cs_pkg::CTL_CLR;
                        n_state      = i2cs_pkg::ST_READY;
                    end
                end
            end
            i2cs_pkg::FN_ERROR: begin
                // highest set flag wins
                if (i_error_flags[i2cs_pkg::ERR_AF]) begin
                    act.gen_stop = 1'b1;
                    n_state      = i2cs_pkg::ST_NACK;
                end
                if (i_error_flags[i2cs_pkg::ERR_BERR]) n_state = i2cs_pkg::ST_BUSERR;
                if (i_error_flags[i2cs_pkg::ERR_ARLO]) n_state = i2cs_pkg::ST_ARLO;
                if (i_error_flags[i2cs_pkg::ERR_OVR])  n_state = i2cs_pkg::ST_OVR;
                act.irq_ctrl = i2cs_pkg::CTL_CLR;
            end
            i2cs_pkg::FN_READBUF: begin
                mreq.re         = 1'b1;
                mreq.raddr      = i_index[i2cs_pkg::BUF_AW-1:0];
                act.rd_from_mem = 1'b1;
            end
            default: begin
            end
        endcase
        act.state = n_state;
    end

    // Control state, updated per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= i2cs_pkg::ST_READY;
            r_addr_byte <= '0;
            r_left      <= '0;
            r_pos       <= '0;
        end else if (i_accept) begin
            r_state     <= n_state;
            r_addr_byte <= n_addr_byte;
            r_left      <= n_left;
            r_pos       <= n_pos;
        end
    end

    assign o_act  = act;
    assign o_mreq = i_accept ? mreq : '0;

endmodule

@@ src/i2c_master_transfer_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_core
// A request's decoded actions wait in stage one for the buffer read and are
// joined with the read data when they move on, then held in the output
// register. One request per cycle is taken while the output side does not stall.
// Reset (synchronous, active low) returns the sequencer to ready with empty
// pipeline; buffer contents are undefined until written.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_func,
    input  logic [7:0] i_target_addr,
    input  logic [8:0] i_length,
    input  logic [7:0] i_index,
    input  logic [7:0] i_data_byte,
    input  logic       i_flag_sb,
    input  logic       i_flag_addr,
    input  logic       i_flag_txe,
    input  logic       i_flag_btf,
    input  logic       i_flag_rxne,
    input  logic [3:0] i_error_flags,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_cmd_status,
    output logic [2:0] o_xfer_state_out,
    output logic       o_dr_write_valid,
    output logic [7:0] o_dr_write_data,
    output logic       o_gen_start,
    output logic       o_gen_stop,
    output logic [1:0] o_ack_ctrl,
    output logic [1:0] o_irq_ctrl,
    output logic       o_clear_addr,
    output logic [7:0] o_read_data
);

    logic            accept;
    logic            s1_go;
    i2cs_pkg::t_act  act;
    i2cs_pkg::t_mreq mreq;
    logic [7:0]      rdata;

    logic            r_s1_valid;
    i2cs_pkg::t_act  r_s1_act;
    logic            r_out_valid;
    logic            r_cmd_status;
    logic [2:0]      r_state;
    logic            r_dr_valid;
    logic [7:0]      r_dr_data;
    logic            r_gen_start;
    logic            r_gen_stop;
    logic [1:0]      r_ack_ctrl;
    logic [1:0]      r_irq_ctrl;
    logic            r_clear_addr;
    logic [7:0]      r_read_data;

    // Handshake: stage one moves on when the output register is free
    assign s1_go      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign accept     = i_in_valid && !o_in_stall;

    i2cs_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_func        (i_func),
        .i_target_addr (i_target_addr),
        .i_length      (i_length),
        .i_index       (i_index),
        .i_data_byte   (i_data_byte),
        .i_flag_sb     (i_flag_sb),
        .i_flag_addr   (i_flag_addr),
        .i_flag_txe    (i_flag_txe),
        .i_flag_btf    (i_flag_btf),
        .i_flag_rxne   (i_flag_rxne),
        .i_error_flags (i_error_flags),
        .o_act         (act),
        .o_mreq        (mreq)
    );

    i2cs_buf_ram #(
        .DEPTH (i2cs_pkg::BUF_DEPTH),
        .AW    (i2cs_pkg::BUF_AW),
        .DW    (8)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (mreq.we),
        .i_waddr (mreq.waddr),
        .i_wdata (mreq.wdata),
        .i_re    (mreq.re),
        .i_raddr (mreq.raddr),
        .o_rdata (rdata)
    );

    // Stage one: decoded actions wait for the buffer read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_act <= act;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_cmd_status <= r_s1_act.cmd_status;
            r_state      <= r_s1_act.state;
            r_dr_valid   <= r_s1_act.dr_valid;
            r_dr_data    <= r_s1_act.dr_from_mem ? rdata : r_s1_act.dr_data;
            r_gen_start  <= r_s1_act.gen_start;
            r_gen_stop   <= r_s1_act.gen_stop;
            r_ack_ctrl   <= r_s1_act.ack_ctrl;
            r_irq_ctrl   <= r_s1_act.irq_ctrl;
            r_clear_addr <= r_s1_act.clear_addr;
            r_read_data  <= r_s1_act.rd_from_mem ? rdata : 8'h00;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_cmd_status     = r_cmd_status;
    assign o_xfer_state_out = r_state;
    assign o_dr_write_valid = r_dr_valid;
    assign o_dr_write_data  = r_dr_data;
    assign o_gen_start      = r_gen_start;
    assign o_gen_stop       = r_gen_stop;
    assign o_ack_ctrl       = r_ack_ctrl;
    assign o_irq_ctrl       = r_irq_ctrl;
    assign o_clear_addr     = r_clear_addr;
    assign o_read_data      = r_read_data;

    // Input is held off only behind a full, stalled output register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a full output");

    // A stalled stage-one request stays put for the next cycle
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_go) |=> (r_s1_valid && $stable(r_s1_act)))
        else $error("stage one request lost while stalled");

    // A refused start never asks for a start condition
    a_refused_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_cmd_status) |-> (!r_gen_start && r_irq_ctrl == i2cs_pkg::CTL_KEEP))
        else $error("refused start produced start actions");

    // No data-register byte without its strobe
    a_dr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_dr_valid) |-> (r_dr_data == 8'h00))
        else $error("data-register byte without write strobe");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C master transfer sequencer core. Requests
// go in through a valid/stall port in random bursts, results are taken under
// a random stall pattern, and each result is checked field by field against
// an in-bench model of the transfer sequencing. Directed cases come first,
// then random write/read transfers with noise mixed in.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Function codes the block ignores
    localparam logic [2:0] FN_SPARE_A = 3'd6;
    localparam logic [2:0] FN_SPARE_B = 3'd7;

    localparam int unsigned TIMEOUT_CYCLES = 400000;
    localparam int          DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] target;
        logic [8:0] len;
        logic [7:0] idx;
        logic [7:0] data;
        logic       sb;
        logic       adr;
        logic       txe;
        logic       btf;
        logic       rxne;
        logic [3:0] errs;
    } t_request;

    typedef struct packed {
        logic       cmd_status;
        logic [2:0] state;
        logic       dr_valid;
        logic [7:0] dr_data;
        logic       gen_start;
        logic       gen_stop;
        logic [1:0] ack_ctrl;
        logic [1:0] irq_ctrl;
        logic       clear_addr;
        logic [7:0] read_data;
    } t_action;

    // DUT ports
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [2:0] i_func = '0;
    logic [7:0] i_target_addr = '0;
    logic [8:0] i_length = '0;
    logic [7:0] i_index = '0;
    logic [7:0] i_data_byte = '0;
    logic       i_flag_sb = 1'b0;
    logic       i_flag_addr = 1'b0;
    logic       i_flag_txe = 1'b0;
    logic       i_flag_btf = 1'b0;
    logic       i_flag_rxne = 1'b0;
    logic [3:0] i_error_flags = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_cmd_status;
    logic [2:0] o_xfer_state_out;
    logic       o_dr_write_valid;
    logic [7:0] o_dr_write_data;
    logic       o_gen_start;
    logic       o_gen_stop;
    logic [1:0] o_ack_ctrl;
    logic [1:0] o_irq_ctrl;
    logic       o_clear_addr;
    logic [7:0] o_read_data;

    // Sequencer model state
    logic [2:0] xfer_state = i2cs_pkg::ST_READY;
    logic [7:0] xfer_addr = '0;
    logic [8:0] xfer_left = '0;
    logic [7:0] xfer_pos = '0;
    logic [7:0] xfer_mem [i2cs_pkg::BUF_DEPTH];
    bit         mem_written [i2cs_pkg::BUF_DEPTH];

    t_action     pending_actions [$];
    int          failures = 0;
    int          items_sent = 0;
    int unsigned cycle_count = 0;

    // Idling controls
    int burst_left = 0;
    int gap_max = 0;
    int stall_pct = 0;
    int stall_run_max = 1;
    int stall_run = 0;
    bit stall_hold = 1'b0;

    i2c_master_transfer_sequencer_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_target_addr    (i_target_addr),
        .i_length         (i_length),
        .i_index          (i_index),
        .i_data_byte      (i_data_byte),
        .i_flag_sb        (i_flag_sb),
        .i_flag_addr      (i_flag_addr),
        .i_flag_txe       (i_flag_txe),
        .i_flag_btf       (i_flag_btf),
        .i_flag_rxne      (i_flag_rxne),
        .i_error_flags    (i_error_flags),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_cmd_status     (o_cmd_status),
        .o_xfer_state_out (o_xfer_state_out),
        .o_dr_write_valid (o_dr_write_valid),
        .o_dr_write_data  (o_dr_write_data),
        .o_gen_start      (o_gen_start),
        .o_gen_stop       (o_gen_stop),
        .o_ack_ctrl       (o_ack_ctrl),
        .o_irq_ctrl       (o_irq_ctrl),
        .o_clear_addr     (o_clear_addr),
        .o_read_data      (o_read_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog
    initial begin
        while (cycle_count < TIMEOUT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** i2c_master_transfer_sequencer_core: FAILED **");
        $finish;
    end

    // Result side stall pattern: runs of stall or no stall of random length
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_hold = ($urandom_range(1, 100) <= stall_pct);
            stall_run  = $urandom_range(1, stall_run_max);
        end
        stall_run--;
        i_out_stall <= stall_hold;
    end

    // Sequencer model: actions and state after one request
    function automatic t_action next_actions(input t_request r);
        t_action a;
        a = '0;
        case (r.func)
            i2cs_pkg::FN_LOAD: begin
                xfer_mem[r.idx]    = r.data;
                mem_written[r.idx] = 1'b1;
            end
            i2cs_pkg::FN_START_W, i2cs_pkg::FN_START_R: begin
                if (xfer_state != i2cs_pkg::ST_READY) begin
                    a.cmd_status = 1'b1;
                end else begin
                    xfer_left   = r.len;
                    xfer_pos    = '0;
                    a.gen_start = 1'b1;
                    a.irq_ctrl  = i2cs_pkg::CTL_SET;
                    if (r.func == i2cs_pkg::FN_START_W) begin
                        xfer_addr  = r.target;
                        xfer_state = i2cs_pkg::ST_BUSY_TX;
                    end else begin
                        xfer_addr  = r.target | i2cs_pkg::READ_BIT_MASK;
                        xfer_state = i2cs_pkg::ST_BUSY_RX;
                        a.ack_ctrl = i2cs_pkg::CTL_SET;
                    end
                end
            end
            i2cs_pkg::FN_EVENT: begin
                if (r.sb) begin
                    // start generated: only the address byte goes out
                    a.dr_valid = 1'b1;
                    a.dr_data  = xfer_addr;
                end else begin
                    if (r.adr) begin
                        if (xfer_state == i2cs_pkg::ST_BUSY_RX && xfer_left == 9'd1) begin
                            a.ack_ctrl = i2cs_pkg::CTL_CLR;
                            a.gen_stop = 1'b1;
                        end
                        a.clear_addr = 1'b1;
                    end
                    if (r.txe && !r.btf && xfer_state == i2cs_pkg::ST_BUSY_TX
                        && xfer_left != 0) begin
                        a.dr_valid = 1'b1;
                        a.dr_data  = xfer_mem[xfer_pos];
                        xfer_pos   = xfer_pos + 8'd1;
                        xfer_left  = xfer_left - 9'd1;
                    end
                    // receive acts in any state
                    if (r.rxne) begin
                        xfer_mem[xfer_pos]    = r.data;
                        mem_written[xfer_pos] = 1'b1;
                        xfer_pos              = xfer_pos + 8'd1;
                        if (xfer_left > 9'd1) begin
                            if (xfer_left == 9'd2) begin
                                a.ack_ctrl = i2cs_pkg::CTL_CLR;
                                a.gen_stop = 1'b1;
                            end
                            xfer_left = xfer_left - 9'd1;
                        end else begin
                            xfer_state = i2cs_pkg::ST_READY;
                            a.irq_ctrl = i2cs_pkg::CTL_CLR;
                        end
                    end
                    if (r.btf && xfer_state == i2cs_pkg::ST_BUSY_TX && xfer_left == 0) begin
                        a.gen_stop = 1'b1;
                        a.irq_ctrl = i2cs_pkg::CTL_CLR;
                        xfer_state = i2cs_pkg::ST_READY;
                    end
                end
            end
            i2cs_pkg::FN_ERROR: begin
                // highest set flag wins
                if (r.errs[i2cs_pkg::ERR_AF]) begin
                    a.gen_stop = 1'b1;
                    xfer_state = i2cs_pkg::ST_NACK;
                end
                if (r.errs[i2cs_pkg::ERR_BERR]) xfer_state = i2cs_pkg::ST_BUSERR;
                if (r.errs[i2cs_pkg::ERR_ARLO]) xfer_state = i2cs_pkg::ST_ARLO;
                if (r.errs[i2cs_pkg::ERR_OVR])  xfer_state = i2cs_pkg::ST_OVR;
                a.irq_ctrl = i2cs_pkg::CTL_CLR;
            end
            i2cs_pkg::FN_READBUF: begin
                a.read_data = xfer_mem[r.idx];
            end
            default: ;
        endcase
        a.state = xfer_state;
        return a;
    endfunction

    // True when the request would fetch a buffer entry never written
    function automatic bit reads_unwritten(input t_request r);
        if (r.func == i2cs_pkg::FN_READBUF)
            return !mem_written[r.idx];
        if (r.func == i2cs_pkg::FN_EVENT && !r.sb && r.txe && !r.btf &&
            xfer_state == i2cs_pkg::ST_BUSY_TX && xfer_left != 0)
            return !mem_written[xfer_pos];
        return 1'b0;
    endfunction

    // Mostly short transfers, a few from half the buffer up to the full buffer
    function automatic logic [8:0] pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return 9'd256;
        if (roll < 5)
            return 9'($urandom_range(128, 255));
        return 9'($urandom_range(0, 8));
    endfunction

    function automatic t_request random_request();
        t_request r;
        r.func   = 3'($urandom_range(0, 7));
        r.target = 8'($urandom);
        r.len    = pick_length();
        r.idx    = 8'($urandom);
        r.data   = 8'($urandom);
        r.sb     = 1'($urandom_range(0, 1));
        r.adr    = 1'($urandom_range(0, 1));
        r.txe    = 1'($urandom_range(0, 1));
        r.btf    = 1'($urandom_range(0, 1));
        r.rxne   = 1'($urandom_range(0, 1));
        r.errs   = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0;
        return r;
    endfunction

    function automatic t_request load_req(input logic [7:0] idx, input logic [7:0] data);
        t_request r;
        r      = random_request();
        r.func = i2cs_pkg::FN_LOAD;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic t_request readback_req(input logic [7:0] idx);
        t_request r;
        r      = random_request();
        r.func = i2cs_pkg::FN_READBUF;
        r.idx  = idx;
        return r;
    endfunction

    function automatic t_request start_req(input logic [2:0] func, input logic [7:0] target,
                                           input logic [8:0] len);
        t_request r;
        r        = random_request();
        r.func   = func;
        r.target = target;
        r.len    = len;
        return r;
    endfunction

    function automatic t_request event_req(input logic sb, input logic adr, input logic txe,
                                           input logic btf, input logic rxne,
                                           input logic [7:0] data);
        t_request r;
        r      = random_request();
        r.func = i2cs_pkg::FN_EVENT;
        r.sb   = sb;
        r.adr  = adr;
        r.txe  = txe;
        r.btf  = btf;
        r.rxne = rxne;
        r.data = data;
        return r;
    endfunction

    function automatic t_request error_req(input logic [3:0] errs);
        t_request r;
        r      = random_request();
        r.func = i2cs_pkg::FN_ERROR;
        r.errs = errs;
        return r;
    endfunction

    // Sends one request; entered and left at a falling edge, valid left high
    task automatic push_request(input t_request r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_func        <= r.func;
        i_target_addr <= r.target;
        i_length      <= r.len;
        i_index       <= r.idx;
        i_data_byte   <= r.data;
        i_flag_sb     <= r.sb;
        i_flag_addr   <= r.adr;
        i_flag_txe    <= r.txe;
        i_flag_btf    <= r.btf;
        i_flag_rxne   <= r.rxne;
        i_error_flags <= r.errs;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_actions.push_back(next_actions(r));
        if (r.func <= i2cs_pkg::FN_READBUF)
            items_sent++;
        @(negedge i_clk);
    endtask

    // Never fetch an unwritten entry: fill it first
    task automatic send_request(input t_request r);
        logic [7:0] fill_idx;
        if (reads_unwritten(r)) begin
            fill_idx = (r.func == i2cs_pkg::FN_READBUF) ? r.idx : xfer_pos;
            push_request(load_req(fill_idx, 8'($urandom)));
        end
        push_request(r);
    endtask

    task automatic set_idling(input int gaps, input int pct, input int run_max);
        gap_max       = gaps;
        stall_pct     = pct;
        stall_run_max = run_max;
    endtask

    // Result check against the oldest expectation
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_action want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_actions.size() == 0) begin
                $error("result with no request waiting");
                failures++;
            end else begin
                want = pending_actions.pop_front();
                check_field("cmd_status", 8'(want.cmd_status), 8'(o_cmd_status));
                check_field("xfer_state_out", 8'(want.state), 8'(o_xfer_state_out));
                check_field("dr_write_valid", 8'(want.dr_valid), 8'(o_dr_write_valid));
                check_field("dr_write_data", want.dr_data, o_dr_write_data);
                check_field("gen_start", 8'(want.gen_start), 8'(o_gen_start));
                check_field("gen_stop", 8'(want.gen_stop), 8'(o_gen_stop));
                check_field("ack_ctrl", 8'(want.ack_ctrl), 8'(o_ack_ctrl));
                check_field("irq_ctrl", 8'(want.irq_ctrl), 8'(o_irq_ctrl));
                check_field("clear_addr", 8'(want.clear_addr), 8'(o_clear_addr));
                check_field("read_data", want.read_data, o_read_data);
            end
        end
    end

    // Drive the model back to ready with well-formed events
    task automatic bring_to_ready();
        while (xfer_state != i2cs_pkg::ST_READY) begin
            if (xfer_state == i2cs_pkg::ST_BUSY_TX && xfer_left == 0)
                send_request(event_req(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'($urandom)));
            else if (xfer_state == i2cs_pkg::ST_BUSY_TX)
                send_request(event_req(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'($urandom)));
            else
                send_request(event_req(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'($urandom)));
        end
    endtask

    task automatic maybe_noise();
        if ($urandom_range(0, 11) == 0)
            send_request(random_request());
    endtask

    // One write or read transfer with random content and the odd stray request
    task automatic run_transfer();
        bit         is_read;
        logic [8:0] n;
        bring_to_ready();
        repeat ($urandom_range(0, 3)) send_request(load_req(8'($urandom), 8'($urandom)));
        is_read = 1'($urandom_range(0, 1));
        n       = pick_length();
        send_request(start_req(is_read ? i2cs_pkg::FN_START_R : i2cs_pkg::FN_START_W,
                               8'($urandom), n));
        maybe_noise();
        send_request(event_req(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'($urandom)));
        maybe_noise();
        if (is_read) begin
            send_request(event_req(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'($urandom)));
            repeat ((n == 0) ? 1 : n) begin
                maybe_noise();
                send_request(event_req(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'($urandom)));
            end
        end else begin
            // address acknowledge sometimes arrives with the first TXE
            send_request(event_req(1'b0, 1'b1, 1'($urandom_range(0, 1)), 1'b0, 1'b0,
                                   8'($urandom)));
            repeat (n) begin
                maybe_noise();
                send_request(event_req(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'($urandom)));
            end
            send_request(event_req(1'b0, 1'b0, 1'($urandom_range(0, 1)), 1'b1, 1'b0,
                                   8'($urandom)));
        end
        if ($urandom_range(0, 3) == 0)
            send_request(readback_req(8'($urandom_range(0, 7))));
    endtask

    task automatic test_buffer_access();
        send_request(load_req(8'h00, 8'h00));
        send_request(load_req(8'h01, 8'hFF));
        send_request(load_req(8'hFF, 8'hA5));
        send_request(readback_req(8'hFF));
    endtask

    task automatic test_write_transfer();
        send_request(start_req(i2cs_pkg::FN_START_W, 8'hFF, 9'd2));
        send_request(event_req(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_request(event_req(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        send_request(event_req(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
        // busy: start refused
        send_request(start_req(i2cs_pkg::FN_START_R, 8'h00, 9'd256));
        send_request(event_req(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'hFF));
        // TXE with BTF and nothing left: stop
        send_request(event_req(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00));
    endtask

    task automatic test_read_transfer();
        // single byte: ack cleared and stop asked at ADDR
        send_request(start_req(i2cs_pkg::FN_START_R, 8'h00, 9'd1));
        send_request(event_req(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_request(event_req(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        send_request(event_req(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'hFF));
    endtask

    task automatic test_ignored_codes();
        t_request r;
        r      = random_request();
        r.func = FN_SPARE_A;
        send_request(r);
        r.func = FN_SPARE_B;
        send_request(r);
        // no flags: interrupts still disabled
        send_request(error_req(4'h0));
    endtask

    task automatic test_error_states();
        send_request(error_req(4'h1));
        send_request(error_req(4'hF));
        send_request(event_req(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_request(start_req(i2cs_pkg::FN_START_W, 8'h55, 9'd3));
        // receive with one byte left returns to ready
        send_request(event_req(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00));
    endtask

    task automatic test_random_transfers();
        int first;
        first = items_sent;
        set_idling(4, 30, 4);
        while (items_sent - first < 370) run_transfer();
        set_idling(0, 0, 1);
        while (items_sent - first < 740) run_transfer();
        set_idling(8, 60, 12);
        while (items_sent - first < 1100) run_transfer();
    endtask

    task automatic test_random_noise();
        int first;
        first = items_sent;
        set_idling(3, 40, 6);
        while (items_sent - first < 300) begin
            if ($urandom_range(0, 5) == 0)
                bring_to_ready();
            send_request(random_request());
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_idling(0, 0, 1);
        test_buffer_access();
        test_write_transfer();
        test_read_transfer();
        test_ignored_codes();
        test_error_states();
        test_random_transfers();
        test_random_noise();

        // Drain
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_actions.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (failures == 0)
            $display("** i2c_master_transfer_sequencer_core: PASSED **");
        else
            $display("** i2c_master_transfer_sequencer_core: FAILED **");
        $finish;
    end

endmodule
